FILE: rtl/mpr_pkg.sv
package mpr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_BITS       = 4;
    localparam int CFG_RESET      = 4;
    localparam int FRAME_OUT_BITS = 3;
    localparam int FAULT_BITS     = 16;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // outcome of one frame lookup
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } t_lookup;

endpackage

FILE: rtl/mfu_page_replacement.sv
// Channel   Dir  Width              Fields (low bit first)
// s_axis    in   PAGE_BITS to bytes page_number
// m_axis    out  21+PAGE_BITS to bytes hit, frame_index, evicted_valid, evicted_page, fault_total
// cfg       in   4                  frames_in_use (write enable + data)
//
// Each reference first reads the reference count memory, then does the frame lookup,
// victim choice and count write-back; a new item is taken only once the last one has
// left its update state. After reset the count memory is swept to zero, one entry per
// cycle, with s_axis_tready low until the sweep is done. A result
// waits in the output register; a stalled m_axis holds the next item in its update state.
module mfu_page_replacement #(
    parameter int  MAX_FRAMES = mpr_pkg::MAX_FRAMES_DEF,
    parameter int  PAGE_BITS  = mpr_pkg::PAGE_BITS_DEF,
    parameter int  COUNT_BITS = mpr_pkg::COUNT_BITS_DEF,
    localparam int IN_W       = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_USED   = 1 + mpr_pkg::FRAME_OUT_BITS + 1 + PAGE_BITS
                                + mpr_pkg::FAULT_BITS,
    localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // page_number
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit, frame_index, evicted_valid, evicted_page, fault_total
    output logic [OUT_W-1:0]              m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic [mpr_pkg::CFG_BITS-1:0]  i_cfg_wr_data
);
    import mpr_pkg::*;

    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CFG_BITS-1:0]   r_frames;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FAULT_BITS-1:0] r_fault;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  mem_busy;
    logic [COUNT_BITS-1:0] mem_rd_data;
    logic [COUNT_BITS-1:0] new_count;
    logic [CNT_W-1:0]      n_eff;
    logic                  accept;
    logic                  fire;
    t_lookup               look;
    logic [FRAME_W-1:0]    frame;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_BITS-1:0] fault_next;
    logic [31:0]           frame_ext;

    always_comb begin
        if (r_frames == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(r_frames) > MAX_FRAMES) begin
            n_eff = CNT_W'(MAX_FRAMES);
        end else begin
            n_eff = CNT_W'(r_frames);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= CFG_BITS'(CFG_RESET);
        end else if (i_cfg_wr_en) begin
            r_frames <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        accept        = 1'b0;
        fire          = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (!mem_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                accept        = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold until the output register is free or being emptied
                fire = !r_out_valid || m_axis_tready;
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= s_axis_tdata[PAGE_BITS-1:0];
        end
    end

    assign new_count = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;

    mpr_count_mem #(
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (s_axis_tdata[PAGE_BITS-1:0]),
        .i_wr_en   (fire),
        .i_wr_addr (r_page),
        .i_wr_data (new_count),
        .o_rd_data (mem_rd_data),
        .o_busy    (mem_busy)
    );

    mpr_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_frames (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (n_eff),
        .i_page         (r_page),
        .i_upd          (fire),
        .i_new_count    (new_count),
        .o_look         (look),
        .o_frame        (frame),
        .o_evicted_page (evicted_page)
    );

    assign fault_next = (!look.hit && (r_fault != '1)) ? r_fault + 1'b1 : r_fault;
    assign frame_ext  = 32'(frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_fault     <= fault_next;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= OUT_W'({fault_next, evicted_page, look.evict,
                                  frame_ext[FRAME_OUT_BITS-1:0], look.hit});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/mpr_count_mem.sv
module mpr_count_mem #(
    parameter int PAGE_BITS  = mpr_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = mpr_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [PAGE_BITS-1:0]  i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [PAGE_BITS-1:0]  i_wr_addr,
    input  logic [COUNT_BITS-1:0] i_wr_data,
    output logic [COUNT_BITS-1:0] o_rd_data,
    output logic                  o_busy
);
    import mpr_pkg::*;

    localparam int DEPTH = 1 << PAGE_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_clearing;
    logic [PAGE_BITS-1:0]  r_clr_addr;

    logic                  wr_en;
    logic [PAGE_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // the clearing sweep owns the write port until it reaches the last entry
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

FILE: rtl/mpr_frames.sv
module mpr_frames #(
    parameter int  MAX_FRAMES = mpr_pkg::MAX_FRAMES_DEF,
    parameter int  PAGE_BITS  = mpr_pkg::PAGE_BITS_DEF,
    parameter int  COUNT_BITS = mpr_pkg::COUNT_BITS_DEF,
    localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CNT_W-1:0]      i_n,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic                  i_upd,
    input  logic [COUNT_BITS-1:0] i_new_count,
    output mpr_pkg::t_lookup      o_look,
    output logic [FRAME_W-1:0]    o_frame,
    output logic [PAGE_BITS-1:0]  o_evicted_page
);
    import mpr_pkg::*;

    logic [PAGE_BITS-1:0]  r_page [MAX_FRAMES];
    logic [FRAME_W-1:0]    r_rank [MAX_FRAMES];
    logic [COUNT_BITS-1:0] r_cnt  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_occ;

    logic [MAX_FRAMES-1:0] managed;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [FRAME_W-1:0]    f_hit;
    logic [FRAME_W-1:0]    f_empty;
    logic [FRAME_W-1:0]    f_victim;
    logic [FRAME_W-1:0]    f_sel;
    t_lookup               look;

    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            managed[k] = (k < int'(i_n));
            match[k]   = managed[k] && r_occ[k] && (r_page[k] == i_page);
            empty[k]   = managed[k] && !r_occ[k];
        end
    end

    // lowest managed frame wins both searches
    always_comb begin
        f_hit   = '0;
        f_empty = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (match[k]) begin
                f_hit = FRAME_W'(k);
            end
            if (empty[k]) begin
                f_empty = FRAME_W'(k);
            end
        end
    end

    // largest count, then oldest rank; ranks are distinct so the key is unique
    always_comb begin
        f_victim = '0;
        for (int k = 1; k < MAX_FRAMES; k++) begin
            if (managed[k] &&
                ({r_cnt[k], r_rank[k]} > {r_cnt[f_victim], r_rank[f_victim]})) begin
                f_victim = FRAME_W'(k);
            end
        end
    end

    always_comb begin
        look.hit   = |match;
        look.fill  = !look.hit && (|empty);
        look.evict = !look.hit && !(|empty);
        priority if (look.hit) begin
            f_sel = f_hit;
        end else if (look.fill) begin
            f_sel = f_empty;
        end else begin
            f_sel = f_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_upd) begin
            r_occ[f_sel] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                if (FRAME_W'(k) == f_sel) begin
                    if (!look.hit) begin
                        r_page[k] <= i_page;
                    end
                    r_rank[k] <= '0;
                    r_cnt[k]  <= i_new_count;
                end else if (r_occ[k]) begin
                    // age frames that were more recent than the touched one
                    if (look.fill || (r_rank[k] < r_rank[f_sel])) begin
                        r_rank[k] <= r_rank[k] + 1'b1;
                    end
                    // keep every copy of this page in step with the table
                    if (r_page[k] == i_page) begin
                        r_cnt[k] <= i_new_count;
                    end
                end
            end
        end
    end

    assign o_look         = look;
    assign o_frame        = f_sel;
    assign o_evicted_page = look.evict ? r_page[f_sel] : '0;

endmodule
